### rtl/core/rhni_pkg.sv
package rhni_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int WORD_WIDTH  = 32;
  localparam int OUT_CNT_WIDTH = 32;
  localparam int NUM_CLASSES = 5;
  localparam int REG_IDX_WIDTH = 5;
  localparam int OUT_DATA_WIDTH = WORD_WIDTH + 7 * OUT_CNT_WIDTH;
  localparam int OUT_USER_WIDTH = 5;

  localparam logic [WORD_WIDTH-1:0] NOP_WORD = 32'h0000_0013;

  localparam logic [6:0] OP_ALU_REG = 7'b0110011;
  localparam logic [6:0] OP_ALU_IMM = 7'b0010011;
  localparam logic [6:0] OP_JAL     = 7'b1101111;
  localparam logic [6:0] OP_JALR    = 7'b1100111;
  localparam logic [6:0] OP_BRANCH  = 7'b1100011;
  localparam logic [6:0] OP_LOAD    = 7'b0000011;
  localparam logic [6:0] OP_STORE   = 7'b0100011;

  localparam logic [1:0] NOPS_NO_FWD = 2'd2;
  localparam logic [1:0] NOPS_FWD    = 2'd1;

  typedef enum logic [2:0] {
    CLS_ALU    = 3'd0,
    CLS_JUMP   = 3'd1,
    CLS_BRANCH = 3'd2,
    CLS_MEMORY = 3'd3,
    CLS_OTHER  = 3'd4
  } instr_class_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] word;
    instr_class_t          cls;
    logic                  hazard;
  } item_info_t;

  typedef struct packed {
    count_t total;
    count_t alu;
    count_t jump;
    count_t branch;
    count_t memory;
    count_t other;
    count_t hazard;
  } counts_t;

  function automatic logic [OUT_CNT_WIDTH-1:0] to_out_cnt(input count_t c);
    logic [63:0] ext;
    ext = 64'(c);
    return ext[OUT_CNT_WIDTH-1:0];
  endfunction

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

endpackage

### rtl/core/rhni_decode.sv
module rhni_decode (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [rhni_pkg::WORD_WIDTH-1:0]     instr_word,
  output rhni_pkg::item_info_t                info
);

  logic [rhni_pkg::REG_IDX_WIDTH-1:0] prev_dest_r;
  logic [rhni_pkg::REG_IDX_WIDTH-1:0] prev_dest_nxt;
  logic                               prev_valid_r;
  logic                               prev_valid_nxt;
  logic [rhni_pkg::REG_IDX_WIDTH-1:0] rs1;
  logic [rhni_pkg::REG_IDX_WIDTH-1:0] rs2;
  rhni_pkg::instr_class_t             cls;

  assign rs1 = instr_word[19:15];
  assign rs2 = instr_word[24:20];

  always_comb begin
    unique case (instr_word[6:0])
      rhni_pkg::OP_ALU_REG, rhni_pkg::OP_ALU_IMM: cls = rhni_pkg::CLS_ALU;
      rhni_pkg::OP_JAL, rhni_pkg::OP_JALR:        cls = rhni_pkg::CLS_JUMP;
      rhni_pkg::OP_BRANCH:                        cls = rhni_pkg::CLS_BRANCH;
      rhni_pkg::OP_LOAD, rhni_pkg::OP_STORE:      cls = rhni_pkg::CLS_MEMORY;
      default:                                    cls = rhni_pkg::CLS_OTHER;
    endcase
  end

  always_comb begin
    info.word   = instr_word;
    info.cls    = cls;
    info.hazard = prev_valid_r && ((prev_dest_r == rs1) || (prev_dest_r == rs2));
  end

  always_comb begin
    prev_dest_nxt  = prev_dest_r;
    prev_valid_nxt = prev_valid_r;
    if (accept) begin
      prev_dest_nxt  = instr_word[11:7];
      prev_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_dest_r  <= '0;
      prev_valid_r <= 1'b0;
    end else begin
      prev_dest_r  <= prev_dest_nxt;
      prev_valid_r <= prev_valid_nxt;
    end
  end

endmodule

### rtl/core/rhni_counters.sv
module rhni_counters (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  rhni_pkg::item_info_t info,
  output rhni_pkg::counts_t    counts
);

  rhni_pkg::count_t total_r;
  rhni_pkg::count_t total_nxt;
  rhni_pkg::count_t hazard_r;
  rhni_pkg::count_t hazard_nxt;
  rhni_pkg::count_t class_r   [rhni_pkg::NUM_CLASSES];
  rhni_pkg::count_t class_nxt [rhni_pkg::NUM_CLASSES];

  always_comb begin
    total_nxt  = total_r;
    hazard_nxt = hazard_r;
    for (int i = 0; i < rhni_pkg::NUM_CLASSES; i++) begin
      class_nxt[i] = class_r[i];
    end
    if (accept) begin
      total_nxt = rhni_pkg::sat_inc(total_r);
      if (info.hazard) begin
        hazard_nxt = rhni_pkg::sat_inc(hazard_r);
      end
      for (int i = 0; i < rhni_pkg::NUM_CLASSES; i++) begin
        if (info.cls == rhni_pkg::instr_class_t'(i)) begin
          class_nxt[i] = rhni_pkg::sat_inc(class_r[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      hazard_r <= '0;
      for (int i = 0; i < rhni_pkg::NUM_CLASSES; i++) begin
        class_r[i] <= '0;
      end
    end else begin
      total_r  <= total_nxt;
      hazard_r <= hazard_nxt;
      for (int i = 0; i < rhni_pkg::NUM_CLASSES; i++) begin
        class_r[i] <= class_nxt[i];
      end
    end
  end

  always_comb begin
    counts.total  = total_r;
    counts.alu    = class_r[rhni_pkg::CLS_ALU];
    counts.jump   = class_r[rhni_pkg::CLS_JUMP];
    counts.branch = class_r[rhni_pkg::CLS_BRANCH];
    counts.memory = class_r[rhni_pkg::CLS_MEMORY];
    counts.other  = class_r[rhni_pkg::CLS_OTHER];
    counts.hazard = hazard_r;
  end

endmodule

### rtl/core/rhni_emit.sv
module rhni_emit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  forwarding_mode,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  rhni_pkg::item_info_t                  info,
  output logic                                  accept,
  input  rhni_pkg::counts_t                     counts,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [rhni_pkg::OUT_DATA_WIDTH-1:0]   out_tdata,
  output logic [rhni_pkg::OUT_USER_WIDTH-1:0]   out_tuser,
  output logic                                  out_tlast
);

  logic                 valid_r;
  logic                 valid_nxt;
  logic [1:0]           nops_r;
  logic [1:0]           nops_nxt;
  rhni_pkg::item_info_t item_r;
  rhni_pkg::item_info_t item_nxt;
  logic                 on_instr;

  assign on_instr  = (nops_r == 2'd0);
  assign in_tready = !valid_r || (out_tready && on_instr);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    nops_nxt  = nops_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt = 1'b1;
      item_nxt  = info;
      if (info.hazard) begin
        nops_nxt = forwarding_mode ? rhni_pkg::NOPS_FWD : rhni_pkg::NOPS_NO_FWD;
      end else begin
        nops_nxt = 2'd0;
      end
    end else if (valid_r && out_tready) begin
      if (on_instr) begin
        valid_nxt = 1'b0;
      end else begin
        nops_nxt = nops_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      nops_r  <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      nops_r  <= nops_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = on_instr;
  assign out_tuser  = {item_r.hazard, item_r.cls, !on_instr};
  assign out_tdata  = {rhni_pkg::to_out_cnt(counts.hazard),
                       rhni_pkg::to_out_cnt(counts.other),
                       rhni_pkg::to_out_cnt(counts.memory),
                       rhni_pkg::to_out_cnt(counts.branch),
                       rhni_pkg::to_out_cnt(counts.jump),
                       rhni_pkg::to_out_cnt(counts.alu),
                       rhni_pkg::to_out_cnt(counts.total),
                       on_instr ? item_r.word : rhni_pkg::NOP_WORD};

endmodule

### rtl/core/riscv_hazard_nop_inserter.sv
// RV32 data-hazard NOP inserter.
// Input channel in_*: one instruction word per item. Result channel out_*:
// for each instruction, zero, one or two NOP words (0x00000013) and then the
// instruction itself, marked by out_tlast. A NOP follows when rs1 or rs2 of
// the instruction equals the rd field of the one before it; forwarding mode
// (cfg_wr_data, written with cfg_wr_en) selects one NOP instead of two.
// Every result also carries the class, the hazard flag and the saturating
// counters as they stand after its instruction was counted.
// The first result of an item is registered and shown in the cycle after acceptance.
// The single output register sends one result per cycle while out_tready is
// high, so an item with a hazard holds it longer than an item without one.
// An item is taken in the same cycle as the previous item's last result
// leaves. When out_tready is low the output holds and in_tready drops once
// the held result is the instruction itself or NOPs remain.
// Reset clears the counters, the previous-rd record, the mode and the
// output valid; the first instruction after reset is never a hazard.
module riscv_hazard_nop_inserter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,  // forwarding_mode
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rhni_pkg::WORD_WIDTH-1:0]     in_tdata,     // instr_word
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_word, total, alu, jump, branch, memory, other, hazard counts
  output logic [rhni_pkg::OUT_DATA_WIDTH-1:0] out_tdata,
  // is_inserted_nop, instr_class[2:0], hazard_seen
  output logic [rhni_pkg::OUT_USER_WIDTH-1:0] out_tuser,
  output logic                                out_tlast     // last_of_run
);

  logic                 fwd_mode_r;
  logic                 fwd_mode_nxt;
  logic                 accept;
  rhni_pkg::item_info_t info;
  rhni_pkg::counts_t    counts;

  assign fwd_mode_nxt = cfg_wr_en ? cfg_wr_data : fwd_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_mode_r <= 1'b0;
    end else begin
      fwd_mode_r <= fwd_mode_nxt;
    end
  end

  rhni_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .instr_word (in_tdata),
    .info       (info)
  );

  rhni_counters u_counters (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .info   (info),
    .counts (counts)
  );

  rhni_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .forwarding_mode (fwd_mode_r),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .info            (info),
    .accept          (accept),
    .counts          (counts),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast)
  );

endmodule

### rtl/core/rhni_checker.sv
module rhni_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [rhni_pkg::OUT_DATA_WIDTH-1:0] out_tdata,
  input logic [rhni_pkg::OUT_USER_WIDTH-1:0] out_tuser,
  input logic                                out_tlast
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_nop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[31:0] == rhni_pkg::NOP_WORD && !out_tlast && out_tuser[4])
    else $error("inserted NOP malformed");

  a_no_hazard_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[4] |-> out_tlast && !out_tuser[0])
    else $error("NOP without hazard");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken while NOPs pending");

endmodule

bind riscv_hazard_nop_inserter rhni_checker u_rhni_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
